// ----- src/dstq_pkg.sv -----
// ============================================================================
// dstq_pkg: shared types and constants for the deadline sorted timer queue
// Slot pool size, link pointer format, function and result codes, FSM states.
// ============================================================================
package dstq_pkg;

    // Pool geometry
    localparam int SLOTS      = 16;
    localparam int RESULT_CAP = 16;
    localparam int PTR_W      = $clog2(SLOTS);
    localparam int LINK_W     = PTR_W + 1;
    localparam int CNT_W      = $clog2(RESULT_CAP + 1);

    typedef logic [PTR_W-1:0]  slot_t;
    typedef logic [LINK_W-1:0] link_t;
    typedef logic [CNT_W-1:0]  fire_cnt_t;

    // Null marker for list links and the head pointer
    localparam link_t NULL_LINK = link_t'(SLOTS);

    // Input function codes
    localparam logic [1:0] FUNC_INS_ABS = 2'd0;
    localparam logic [1:0] FUNC_INS_DLY = 2'd1;
    localparam logic [1:0] FUNC_POLL    = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_ACCEPT = 2'd0;
    localparam logic [1:0] KIND_REJECT = 2'd1;
    localparam logic [1:0] KIND_FIRED  = 2'd2;
    localparam logic [1:0] KIND_NONE   = 2'd3;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_HEAD,
        ST_WALK,
        ST_FIX,
        ST_RESP,
        ST_POLL
    } state_t;

    // A link is null when it does not point at a real slot
    function automatic logic link_is_null(input link_t l);
        return (l >= NULL_LINK);
    endfunction

endpackage

// ----- src/deadline_sorted_timer_queue_unit.sv -----
// ============================================================================
// deadline_sorted_timer_queue_unit: sorted timer list over a fixed slot pool
// Inserts tagged deadlines into a linked list sorted by deadline, fires due
// entries on poll. One sequencer walks the list one slot per cycle.
// ============================================================================
// Usage:
//   Input channel (in_valid/in_stall) carries func, task_tag, when_value, now.
//   in_stall is high whenever the sequencer is busy; one item is handled at a
//   time. Output channel (out_valid/out_stall) carries kind, fired_tag, last;
//   last marks the final result of an input item.
// Sequence:
//   Insert: transfer, free-slot search (one slot checked per cycle), head
//   check, list walk (one link per cycle), link fix, response. A new head
//   skips the walk and fix; a full pool or failed search goes to response.
//   Poll: one result per fired entry, last flagged, or one none result.
//   The list walk and the poll due test share a single deadline comparator.
// Reset:
//   All slots free, list empty, search rover at slot 0, output empty.
// Back-pressure:
//   A stalled result holds in the output register; the sequencer waits on it
//   and in_stall stays high until the item's last result has been loaded.
// ============================================================================
module deadline_sorted_timer_queue_unit
    import dstq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic [15:0] task_tag,
    input  logic [31:0] when_value,
    input  logic [31:0] now,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [15:0] fired_tag,
    output logic        last
);

    // Slot storage
    logic [31:0]      dl_mem   [SLOTS];
    logic [15:0]      tag_mem  [SLOTS];
    link_t            next_mem [SLOTS];
    logic [SLOTS-1:0] busy_reg, busy_next;

    // Control state
    state_t    state_reg, state_next;
    link_t     head_reg, head_next;
    link_t     used_reg, used_next;
    slot_t     rover_reg, rover_next;
    slot_t     cnt_reg, cnt_next;
    fire_cnt_t fired_reg, fired_next;
    logic      pend_valid_reg, pend_valid_next;
    logic      out_valid_reg, out_valid_next;

    // Item and payload registers
    logic [15:0] tag_reg, tag_next;
    logic [31:0] dl_reg, dl_next;
    logic [31:0] now_reg, now_next;
    slot_t       slot_reg, slot_next;
    slot_t       cur_reg, cur_next;
    logic [1:0]  resp_kind_reg, resp_kind_next;
    logic [15:0] pend_tag_reg, pend_tag_next;
    logic [1:0]  kind_reg, kind_next;
    logic [15:0] fired_tag_reg, fired_tag_next;
    logic        last_reg, last_next;

    // Storage write controls
    logic        slot_wr;
    logic        link_wr;
    slot_t       link_wr_addr;
    link_t       link_wr_data;

    // Shared read path and comparator
    logic        in_xfer;
    logic        out_free;
    logic        head_null;
    slot_t       head_idx;
    slot_t       nx_addr;
    link_t       nx_rd;
    logic        nx_null;
    slot_t       dl_addr;
    logic [31:0] dl_rd;
    logic [31:0] cmp_a;
    logic [31:0] cmp_b;
    logic        dl_ge;
    logic        due;
    logic        pool_full;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign fired_tag = fired_tag_reg;
    assign last      = last_reg;

    assign head_null = link_is_null(head_reg);
    assign head_idx  = head_reg[PTR_W-1:0];
    assign pool_full = (used_reg >= link_t'(SLOTS));

    // One read address per array per cycle
    assign nx_addr = (state_reg == ST_POLL) ? head_idx : cur_reg;
    assign nx_rd   = next_mem[nx_addr];
    assign nx_null = link_is_null(nx_rd);
    assign dl_addr = (state_reg == ST_WALK) ? nx_rd[PTR_W-1:0] : head_idx;
    assign dl_rd   = dl_mem[dl_addr];

    // Shared comparator: list position test, operands swapped for the due test
    assign cmp_a = (state_reg == ST_POLL) ? now_reg : dl_rd;
    assign cmp_b = (state_reg == ST_POLL) ? dl_rd : dl_reg;
    assign dl_ge = (cmp_a >= cmp_b);
    assign due   = !head_null && (fired_reg < fire_cnt_t'(RESULT_CAP)) && dl_ge;

    // Next-state logic
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    case (func)
                        FUNC_INS_ABS, FUNC_INS_DLY:
                            state_next = pool_full ? ST_RESP : ST_SEARCH;
                        FUNC_POLL:
                            state_next = ST_POLL;
                        default:
                            state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SEARCH:
            begin
                if (!busy_reg[rover_reg])
                    state_next = ST_HEAD;
                else if (cnt_reg == slot_t'(SLOTS - 1))
                    state_next = ST_RESP;
            end
            ST_HEAD:
            begin
                state_next = (head_null || dl_ge) ? ST_RESP : ST_WALK;
            end
            ST_WALK:
            begin
                if (nx_null || dl_ge)
                    state_next = ST_FIX;
            end
            ST_FIX:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            ST_POLL:
            begin
                if (!due && out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and output logic
    always_comb
    begin
        head_next       = head_reg;
        used_next       = used_reg;
        rover_next      = rover_reg;
        cnt_next        = cnt_reg;
        fired_next      = fired_reg;
        pend_valid_next = pend_valid_reg;
        busy_next       = busy_reg;
        tag_next        = tag_reg;
        dl_next         = dl_reg;
        now_next        = now_reg;
        slot_next       = slot_reg;
        cur_next        = cur_reg;
        resp_kind_next  = resp_kind_reg;
        pend_tag_next   = pend_tag_reg;
        out_valid_next  = out_valid_reg && out_stall;
        kind_next       = kind_reg;
        fired_tag_next  = fired_tag_reg;
        last_next       = last_reg;
        slot_wr         = 1'b0;
        link_wr         = 1'b0;
        link_wr_addr    = slot_reg;
        link_wr_data    = NULL_LINK;

        case (state_reg)
            ST_IDLE:
            begin
                // Capture the item; delayed inserts get their deadline here
                if (in_xfer)
                begin
                    tag_next        = task_tag;
                    now_next        = now;
                    dl_next         = (func == FUNC_INS_DLY) ? (now + when_value)
                                                             : when_value;
                    cnt_next        = '0;
                    fired_next      = '0;
                    pend_valid_next = 1'b0;
                    resp_kind_next  = pool_full ? KIND_REJECT : KIND_ACCEPT;
                end
            end
            ST_SEARCH:
            begin
                // Round-robin free slot search, one slot per cycle
                if (!busy_reg[rover_reg])
                begin
                    slot_wr             = 1'b1;
                    busy_next[rover_reg] = 1'b1;
                    used_next           = used_reg + 1'b1;
                    slot_next           = rover_reg;
                    resp_kind_next      = KIND_ACCEPT;
                end
                else
                begin
                    rover_next = (rover_reg == slot_t'(SLOTS - 1)) ? '0
                                                                   : rover_reg + 1'b1;
                    cnt_next   = cnt_reg + 1'b1;
                    if (cnt_reg == slot_t'(SLOTS - 1))
                        resp_kind_next = KIND_REJECT;
                end
            end
            ST_HEAD:
            begin
                // New entry goes ahead of a head with equal or later deadline
                if (head_null || dl_ge)
                begin
                    link_wr      = 1'b1;
                    link_wr_addr = slot_reg;
                    link_wr_data = head_reg;
                    head_next    = {1'b0, slot_reg};
                end
                else
                begin
                    cur_next = head_idx;
                end
            end
            ST_WALK:
            begin
                // Step along the list until the successor is not earlier
                if (nx_null || dl_ge)
                begin
                    link_wr      = 1'b1;
                    link_wr_addr = slot_reg;
                    link_wr_data = nx_null ? NULL_LINK : nx_rd;
                end
                else
                begin
                    cur_next = nx_rd[PTR_W-1:0];
                end
            end
            ST_FIX:
            begin
                link_wr      = 1'b1;
                link_wr_addr = cur_reg;
                link_wr_data = {1'b0, slot_reg};
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = resp_kind_reg;
                    fired_tag_next = '0;
                    last_next      = 1'b1;
                end
            end
            ST_POLL:
            begin
                // Fired tag is held in a pending register so the last flag is known
                if (due)
                begin
                    if (!pend_valid_reg || out_free)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            kind_next      = KIND_FIRED;
                            fired_tag_next = pend_tag_reg;
                            last_next      = 1'b0;
                        end
                        pend_valid_next     = 1'b1;
                        pend_tag_next       = tag_mem[head_idx];
                        busy_next[head_idx] = 1'b0;
                        used_next           = used_reg - 1'b1;
                        head_next           = nx_null ? NULL_LINK : nx_rd;
                        fired_next          = fired_reg + 1'b1;
                    end
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    kind_next       = pend_valid_reg ? KIND_FIRED : KIND_NONE;
                    fired_tag_next  = pend_valid_reg ? pend_tag_reg : 16'd0;
                    last_next       = 1'b1;
                    pend_valid_next = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            head_reg       <= NULL_LINK;
            used_reg       <= '0;
            rover_reg      <= '0;
            cnt_reg        <= '0;
            fired_reg      <= '0;
            pend_valid_reg <= 1'b0;
            busy_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            used_reg       <= used_next;
            rover_reg      <= rover_next;
            cnt_reg        <= cnt_next;
            fired_reg      <= fired_next;
            pend_valid_reg <= pend_valid_next;
            busy_reg       <= busy_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        tag_reg       <= tag_next;
        dl_reg        <= dl_next;
        now_reg       <= now_next;
        slot_reg      <= slot_next;
        cur_reg       <= cur_next;
        resp_kind_reg <= resp_kind_next;
        pend_tag_reg  <= pend_tag_next;
        kind_reg      <= kind_next;
        fired_tag_reg <= fired_tag_next;
        last_reg      <= last_next;
    end

    // Slot storage writes
    always_ff @(posedge clk)
    begin
        if (slot_wr)
        begin
            dl_mem[rover_reg]  <= dl_reg;
            tag_mem[rover_reg] <= tag_reg;
        end
        if (link_wr)
            next_mem[link_wr_addr] <= link_wr_data;
    end

endmodule
